@@ hdl/srsf_pkg.sv @@
// Shared types and constants for the sprite record stream filter.
// No dependencies; imported by srsf_ctrl, srsf_dp and the top level.
package srsf_pkg;

  localparam int unsigned MagicLen = 10;
  localparam int unsigned HoldLen  = 10;
  localparam int unsigned IdxW     = $clog2(HoldLen);
  localparam int unsigned MaskW    = 32;

  // Words to replay for one accepted input byte.
  typedef struct packed {
    logic [IdxW-1:0] nbytes;   // 0, 1, 4 or 10 byte words
    logic            last;     // a status word follows
  } plan_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            accept;
    logic            load_byte;
    logic            load_status;
    logic            run_end;
    logic [IdxW-1:0] idx;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic  out_valid;
    plan_t plan;
  } dp_stat_t;

  function automatic logic [7:0] magic_byte(input logic [IdxW-1:0] i);
    logic [7:0] m;
    unique case (i)
      4'd0:    m = 8'h00;
      4'd1:    m = 8'h00;
      4'd2:    m = 8'h47;
      4'd3:    m = 8'h52;
      4'd4:    m = 8'h46;
      4'd5:    m = 8'h82;
      4'd6:    m = 8'h0D;
      4'd7:    m = 8'h0A;
      4'd8:    m = 8'h1A;
      4'd9:    m = 8'h0A;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

@@ hdl/srsf_ctrl.sv @@
// Word sequencer: takes one input byte, then walks its result words out.
// Depends on srsf_pkg.
module srsf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              out_stall,
  input  srsf_pkg::dp_stat_t dp_stat,
  output srsf_pkg::cmd_t    cmd
);
  import srsf_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_BYTES  = 2'd1;
  localparam logic [1:0] ST_STATUS = 2'd2;

  logic [1:0]      state_r, state_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt;
  logic [IdxW-1:0] cnt_r, cnt_nxt;
  logic            last_r, last_nxt;
  logic            out_free;
  logic            last_idx;

  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !dp_stat.out_valid || !out_stall;
  assign last_idx = (idx_r == cnt_r - IdxW'(1));

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    cnt_nxt         = cnt_r;
    last_nxt        = last_r;
    cmd.accept      = 1'b0;
    cmd.load_byte   = 1'b0;
    cmd.load_status = 1'b0;
    cmd.run_end     = 1'b0;
    cmd.idx         = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          idx_nxt    = '0;
          cnt_nxt    = dp_stat.plan.nbytes;
          last_nxt   = dp_stat.plan.last;
          if (dp_stat.plan.nbytes != '0) begin
            state_nxt = ST_BYTES;
          end else if (dp_stat.plan.last) begin
            state_nxt = ST_STATUS;
          end
        end
      end
      ST_BYTES: begin
        if (out_free) begin
          cmd.load_byte = 1'b1;
          cmd.run_end   = last_idx && !last_r;
          idx_nxt       = idx_r + IdxW'(1);
          if (last_idx) begin
            state_nxt = last_r ? ST_STATUS : ST_IDLE;
          end
        end
      end
      ST_STATUS: begin
        if (out_free) begin
          cmd.load_status = 1'b1;
          cmd.run_end     = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      cnt_r   <= '0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

@@ hdl/srsf_dp.sv @@
// Datapath: container parser state, record hold buffer, output register.
// Depends on srsf_pkg.
module srsf_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [7:0]                 in_data_byte,
  input  logic                       in_last_byte,
  input  logic                       cfg_write,
  input  logic [srsf_pkg::MaskW-1:0] cfg_allowed_mask,
  input  logic                       out_stall,
  input  srsf_pkg::cmd_t             cmd,
  output srsf_pkg::dp_stat_t         dp_stat,
  output logic                       out_valid,
  output logic [7:0]                 out_byte,
  output logic                       out_byte_valid,
  output logic                       out_run_end,
  output logic                       out_stream_done,
  output logic [1:0]                 out_status
);
  import srsf_pkg::*;

  localparam logic [2:0] PH_HDR    = 3'd0;
  localparam logic [2:0] PH_LEN    = 3'd1;
  localparam logic [2:0] PH_PREFIX = 3'd2;
  localparam logic [2:0] PH_REC    = 3'd3;
  localparam logic [2:0] PH_BODY   = 3'd4;
  localparam logic [2:0] PH_PASS   = 3'd5;
  localparam logic [2:0] PH_ERR    = 3'd6;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_MAGIC = 2'd1;
  localparam logic [1:0] STAT_BAD   = 2'd2;

  localparam logic [IdxW-1:0] N_ONE  = IdxW'(1);
  localparam logic [IdxW-1:0] N_ID   = IdxW'(4);
  localparam logic [IdxW-1:0] N_HOLD = IdxW'(HoldLen);

  logic [2:0]       phase_r, phase_nxt;
  logic [IdxW-1:0]  cnt_r, cnt_nxt;
  logic [31:0]      len_r, len_nxt;
  logic [31:0]      body_r, body_nxt;
  logic             keep_r, keep_nxt;
  logic [1:0]       err_r, err_nxt;
  logic [MaskW-1:0] mask_r;
  logic [7:0]       hold_r [HoldLen];
  logic [7:0]       cur_r;
  logic             from_hold_r, from_hold;
  logic [1:0]       status_r, status_nxt;

  logic [7:0]       out_byte_r;
  logic             out_valid_r, out_bv_r, out_end_r, out_done_r;
  logic [1:0]       out_status_r;

  logic [31:0]      rec_size;
  logic [8:0]       offset;
  logic             mask_hit;
  plan_t            plan;

  assign rec_size = {hold_r[7], hold_r[6], hold_r[5], hold_r[4]};
  // Depth code 4 maps to offset 0, everything else starts at 16; zoom adds on.
  assign offset   = {1'b0, in_data_byte} + ((hold_r[8][2:0] == 3'd4) ? 9'd0 : 9'd16);
  assign mask_hit = (offset[8:5] == 4'd0) && mask_r[offset[4:0]];

  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    len_nxt     = len_r;
    body_nxt    = body_r;
    keep_nxt    = keep_r;
    err_nxt     = err_r;
    from_hold   = 1'b0;
    plan.nbytes = '0;
    plan.last   = in_last_byte;
    status_nxt  = STAT_BAD;
    unique case (phase_r)
      PH_HDR: begin
        if (in_data_byte != magic_byte(cnt_r)) begin
          err_nxt   = STAT_MAGIC;
          phase_nxt = PH_ERR;
        end else begin
          plan.nbytes = N_ONE;
          cnt_nxt     = cnt_r + IdxW'(1);
          if (cnt_r == IdxW'(MagicLen - 1)) begin
            phase_nxt = PH_LEN;
            cnt_nxt   = '0;
            len_nxt   = '0;
          end
        end
      end
      PH_LEN: begin
        plan.nbytes                 = N_ONE;
        len_nxt[8*cnt_r[1:0] +: 8]  = in_data_byte;
        cnt_nxt                     = cnt_r + IdxW'(1);
        if (cnt_r == IdxW'(3)) begin
          body_nxt  = len_nxt;
          cnt_nxt   = '0;
          phase_nxt = (len_nxt != '0) ? PH_PREFIX : PH_REC;
        end
      end
      PH_PREFIX: begin
        plan.nbytes = N_ONE;
        body_nxt    = body_r - 32'd1;
        if (body_r == 32'd1) begin
          phase_nxt = PH_REC;
          cnt_nxt   = '0;
        end
      end
      PH_REC: begin
        cnt_nxt = cnt_r + IdxW'(1);
        if (cnt_r == IdxW'(3) && hold_r[0] == 8'h00 && hold_r[1] == 8'h00 &&
            hold_r[2] == 8'h00 && in_data_byte == 8'h00) begin
          // zero id: replay the id and pass everything after it
          plan.nbytes = N_ID;
          from_hold   = 1'b1;
          phase_nxt   = PH_PASS;
        end else if (cnt_r == IdxW'(HoldLen - 1)) begin
          cnt_nxt = '0;
          if (rec_size[31:1] == 31'd0) begin
            err_nxt   = STAT_BAD;
            phase_nxt = PH_ERR;
          end else begin
            keep_nxt = (hold_r[8] == 8'hFF) || mask_hit;
            if (keep_nxt && !in_last_byte) begin
              plan.nbytes = N_HOLD;
              from_hold   = 1'b1;
            end
            body_nxt  = rec_size - 32'd2;
            phase_nxt = (body_nxt != '0) ? PH_BODY : PH_REC;
          end
        end
      end
      PH_BODY: begin
        if (keep_r) plan.nbytes = N_ONE;
        body_nxt = body_r - 32'd1;
        if (body_r == 32'd1) begin
          phase_nxt = PH_REC;
          cnt_nxt   = '0;
        end
      end
      PH_PASS: plan.nbytes = N_ONE;
      default: ;
    endcase

    if (err_nxt != STAT_OK) begin
      status_nxt = err_nxt;
    end else if (phase_nxt == PH_HDR || (phase_nxt == PH_LEN && cnt_nxt == '0)) begin
      status_nxt = STAT_MAGIC;
    end else if (phase_nxt == PH_PASS) begin
      status_nxt = STAT_OK;
    end

    if (in_last_byte) begin
      phase_nxt = PH_HDR;
      cnt_nxt   = '0;
      len_nxt   = '0;
      body_nxt  = '0;
      keep_nxt  = 1'b0;
      err_nxt   = STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR;
      cnt_r   <= '0;
      len_r   <= '0;
      body_r  <= '0;
      keep_r  <= 1'b0;
      err_r   <= STAT_OK;
      mask_r  <= MaskW'(1);
    end else begin
      if (cfg_write) mask_r <= cfg_allowed_mask;
      if (cmd.accept) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        len_r   <= len_nxt;
        body_r  <= body_nxt;
        keep_r  <= keep_nxt;
        err_r   <= err_nxt;
      end
    end
  end

  // hold buffer and per-byte payload, written before read
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_r       <= in_data_byte;
      from_hold_r <= from_hold;
      status_r    <= status_nxt;
      if (phase_r == PH_REC && cnt_r < N_HOLD) hold_r[cnt_r] <= in_data_byte;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_byte || cmd.load_status) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      out_byte_r   <= from_hold_r ? hold_r[cmd.idx] : cur_r;
      out_bv_r     <= 1'b1;
      out_end_r    <= cmd.run_end;
      out_done_r   <= 1'b0;
      out_status_r <= STAT_OK;
    end else if (cmd.load_status) begin
      out_byte_r   <= 8'h00;
      out_bv_r     <= 1'b0;
      out_end_r    <= cmd.run_end;
      out_done_r   <= 1'b1;
      out_status_r <= status_r;
    end
  end

  assign dp_stat.out_valid = out_valid_r;
  assign dp_stat.plan      = plan;
  assign out_valid         = out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_byte_valid    = out_bv_r;
  assign out_run_end       = out_end_r;
  assign out_stream_done   = out_done_r;
  assign out_status        = out_status_r;

endmodule

@@ hdl/sprite_record_stream_filter_unit.sv @@
// Sprite record stream filter. Takes a container stream one byte per word,
// checks the 10-byte magic, forwards the length field and the prefix it
// covers, then filters records by depth/zoom against cfg_allowed_mask
// (info 0xFF is always kept; a record with zero id switches to passthrough).
// Bytes are forwarded before the stream is known good: at the word marked
// in_last_byte a status word follows (0 ok, 1 bad magic, 2 invalid or
// truncated) and the consumer must drop the output if it is not 0.
// Timing: each byte holds the input until all result words it causes are
// loaded, since results leave through a single output register, one per
// cycle while out_stall is low: a dropped body byte causes no word, a
// forwarded byte one, a kept record header ten (the held bytes replayed),
// a zero id four; the final byte adds the status word. The output register
// decouples the sides, so a byte is taken while a result still waits.
// Depends on srsf_pkg, srsf_ctrl and srsf_dp.
module sprite_record_stream_filter_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  // input words
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_data_byte,
  input  logic                       in_last_byte,
  // configuration
  input  logic                       cfg_write,
  input  logic [srsf_pkg::MaskW-1:0] cfg_allowed_mask,
  // result words
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 out_byte,
  output logic                       out_byte_valid,
  output logic                       out_run_end,
  output logic                       out_stream_done,
  output logic [1:0]                 out_status
);
  import srsf_pkg::*;

  cmd_t     cmd;
  dp_stat_t dp_stat;

  // sequencer: owns the input handshake and paces result words
  srsf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .dp_stat   (dp_stat),
    .cmd       (cmd)
  );

  // parser, record hold buffer and output register
  srsf_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .cfg_write        (cfg_write),
    .cfg_allowed_mask (cfg_allowed_mask),
    .out_stall        (out_stall),
    .cmd              (cmd),
    .dp_stat          (dp_stat),
    .out_valid        (out_valid),
    .out_byte         (out_byte),
    .out_byte_valid   (out_byte_valid),
    .out_run_end      (out_run_end),
    .out_stream_done  (out_stream_done),
    .out_status       (out_status)
  );

endmodule
